// ===== rtl/core/bsdl_pkg.sv =====
// Package: widths, action and status codes, sequencer states and request/response words for the list core.
package bsdl_pkg;
    localparam int Capacity = 32;
    localparam int IdxW     = $clog2(Capacity);
    localparam int LinkW    = IdxW + 1;
    localparam int CntW     = 6;
    localparam int KeyW     = 32;
    localparam int ValW     = 8;

    typedef logic [LinkW-1:0] t_link;

    localparam t_link NilLink = t_link'(Capacity);

    typedef enum logic [2:0] {
        ACT_INS_HEAD = 3'd0,
        ACT_INS_TAIL = 3'd1,
        ACT_INS_ASC  = 3'd2,
        ACT_INS_DESC = 3'd3,
        ACT_EXT_HEAD = 3'd4,
        ACT_EXT_TAIL = 3'd5,
        ACT_EXT_KEY  = 3'd6,
        ACT_SEARCH   = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_CHK,
        S_LINK_RD,
        S_LINK_WR,
        S_UNLINK_RD,
        S_UNLINK_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]      action;
        logic [KeyW-1:0] key;
        logic [ValW-1:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]      status;
        logic [KeyW-1:0] out_key;
        logic [ValW-1:0] out_value;
        logic [CntW-1:0] entry_count;
    } t_rsp;
endpackage

// ===== rtl/core/bsdl_if.sv =====
// Interfaces: request and response word channels with valid/ready.
interface bsdl_req_if;
    import bsdl_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bsdl_rsp_if;
    import bsdl_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/bounded_sorted_deque_list_core.sv =====
// Top level: bounded doubly linked list of keyed records held in on-chip memory.
//
// Usage
//   i_req carries one word per request: action, key and value. o_rsp gives
//   exactly one word per request: status, record key/value and entry count.
//   A request is taken only when the core is idle and the response register
//   is empty; one request is worked on at a time.
// Sequence (acceptance to response)
//   Full insert or empty extract: straight to the done state. Head/tail
//   insert: link read, link write, done; head/tail extract: unlink read,
//   unlink write, done. Sorted insert, extract by key and search walk the
//   list node by node (a read of the node memory, then the compare), over
//   at most the N records held. The registered read sets the walk rate.
// Request flow
//   The next request is taken the cycle after the response word leaves, so
//   a new request is never taken before the last one is through.
// Reset
//   Synchronous, active low. Head and tail go null, count to zero, all slots
//   free. The node memories are not cleared: only linked slots are read.
// Stall
//   The response waits in its register while o_rsp.ready is low; no new
//   request is taken until it has gone.
module bounded_sorted_deque_list_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bsdl_req_if.sink     i_req,
    bsdl_rsp_if.source   o_rsp
);
    import bsdl_pkg::*;

    // node memory: key, value, next, prev per slot
    logic [KeyW-1:0]  m_key  [Capacity];
    logic [ValW-1:0]  m_val  [Capacity];
    t_link            m_next [Capacity];
    t_link            m_prev [Capacity];

    t_state          r_state, n_state;
    t_req            r_req;
    t_link           r_head, r_tail;
    logic [CntW-1:0] r_count;
    logic [Capacity-1:0] r_free;
    t_link           r_at;       // walk cursor / target slot
    logic [IdxW-1:0] r_slot;     // slot being inserted
    logic [5:0]      r_steps;
    t_rsp            r_rsp;
    logic            r_rsp_vld;

    // registered read port
    logic [IdxW-1:0] rd_addr;
    logic [KeyW-1:0] r_rd_key;
    logic [ValW-1:0] r_rd_val;
    t_link           r_rd_next, r_rd_prev;

    // free slot search, lowest first
    logic [IdxW-1:0] free_idx;
    logic            free_any;
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = Capacity - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                free_idx = IdxW'(i);
                free_any = 1'b1;
            end
        end
    end

    logic accept;
    assign accept       = i_req.valid && i_req.ready;
    assign i_req.ready  = (r_state == S_IDLE) && !r_rsp_vld;
    assign o_rsp.valid  = r_rsp_vld;
    assign o_rsp.data   = r_rsp;

    logic is_ins;
    assign is_ins = !r_req.action[2];

    // walk stop condition at the node just read
    logic key_eq, walk_stop;
    always_comb begin
        key_eq = (r_rd_key == r_req.key);
        case (t_action'(r_req.action))
            ACT_INS_ASC:  walk_stop = !($signed(r_rd_key) < $signed(r_req.key));
            ACT_INS_DESC: walk_stop = !($signed(r_rd_key) > $signed(r_req.key));
            default:      walk_stop = key_eq;
        endcase
    end

    always_comb begin
        rd_addr = r_at[IdxW-1:0];
        if (r_state == S_IDLE) begin
            rd_addr = i_req.data.action == ACT_EXT_TAIL ? r_tail[IdxW-1:0]
                                                         : r_head[IdxW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_key  <= m_key[rd_addr];
        r_rd_val  <= m_val[rd_addr];
        r_rd_next <= m_next[rd_addr];
        r_rd_prev <= m_prev[rd_addr];
    end

    // neighbours of the target slot, from the read port
    t_link pv, nx;
    always_comb begin
        nx = r_rd_next;
        pv = r_rd_prev;
        if (r_state == S_LINK_WR && r_at == NilLink) pv = r_tail;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) begin
                if (!i_req.data.action[2]) begin
                    if (r_count >= CntW'(Capacity) || !free_any) n_state = S_DONE;
                    else if (r_count == '0 || i_req.data.action == ACT_INS_HEAD
                             || i_req.data.action == ACT_INS_TAIL) n_state = S_LINK_RD;
                    else n_state = S_WALK_RD;
                end else if (i_req.data.action == ACT_SEARCH
                             || i_req.data.action == ACT_EXT_KEY) begin
                    n_state = (r_count == '0) ? S_DONE : S_WALK_RD;
                end else begin
                    n_state = (r_count == '0) ? S_DONE : S_UNLINK_RD;
                end
            end
            S_WALK_RD:  n_state = S_WALK_CHK;
            S_WALK_CHK: begin
                if (walk_stop) n_state = is_ins ? S_LINK_RD
                                   : (r_req.action == ACT_SEARCH ? S_DONE : S_UNLINK_WR);
                else if (r_rd_next == NilLink || r_steps == 6'(Capacity - 1))
                    n_state = is_ins ? S_LINK_RD : S_DONE;
                else n_state = S_WALK_RD;
            end
            S_LINK_RD:   n_state = S_LINK_WR;
            S_LINK_WR:   n_state = S_DONE;
            S_UNLINK_RD: n_state = S_UNLINK_WR;
            S_UNLINK_WR: n_state = S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // datapath and memory writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= NilLink;
            r_tail    <= NilLink;
            r_count   <= '0;
            r_free    <= '1;
            r_rsp_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_rsp.valid && o_rsp.ready) r_rsp_vld <= 1'b0;
            case (r_state)
                S_IDLE: if (accept) begin
                    r_req        <= i_req.data;
                    r_slot       <= free_idx;
                    r_steps      <= '0;
                    r_rsp.out_key     <= i_req.data.key;
                    r_rsp.out_value   <= '0;
                    r_rsp.entry_count <= r_count;
                    if (!i_req.data.action[2]) begin
                        r_rsp.status <= (r_count >= CntW'(Capacity) || !free_any)
                                        ? ST_FULL : ST_OK;
                        r_at <= (r_count == '0 || i_req.data.action == ACT_INS_HEAD)
                                ? r_head : (i_req.data.action == ACT_INS_TAIL
                                            ? NilLink : r_head);
                    end else if (i_req.data.action == ACT_SEARCH
                                 || i_req.data.action == ACT_EXT_KEY) begin
                        r_rsp.status <= (r_count == '0)
                            ? ((i_req.data.action == ACT_SEARCH) ? ST_NOT_FOUND : ST_EMPTY)
                            : ST_NOT_FOUND;
                        r_at <= r_head;
                    end else begin
                        r_rsp.status <= (r_count == '0) ? ST_EMPTY : ST_OK;
                        r_at <= (i_req.data.action == ACT_EXT_TAIL) ? r_tail : r_head;
                    end
                end
                S_WALK_CHK: begin
                    if (walk_stop) begin
                        if (!is_ins) begin
                            r_rsp.status    <= ST_OK;
                            r_rsp.out_key   <= r_rd_key;
                            r_rsp.out_value <= r_rd_val;
                        end
                    end else begin
                        r_steps <= r_steps + 6'd1;
                        if (is_ins && (r_rd_next == NilLink
                                       || r_steps == 6'(Capacity - 1))) r_at <= NilLink;
                        else r_at <= r_rd_next;
                    end
                end
                S_UNLINK_RD: begin
                    r_rsp.out_key   <= r_rd_key;
                    r_rsp.out_value <= r_rd_val;
                end
                S_LINK_RD: ;
                S_LINK_WR: begin
                    m_key[r_slot]  <= r_req.key;
                    m_val[r_slot]  <= r_req.value;
                    m_next[r_slot] <= r_at;
                    m_prev[r_slot] <= pv;
                    if (pv != NilLink) m_next[pv[IdxW-1:0]] <= {1'b0, r_slot};
                    else r_head <= {1'b0, r_slot};
                    if (r_at != NilLink) m_prev[r_at[IdxW-1:0]] <= {1'b0, r_slot};
                    else r_tail <= {1'b0, r_slot};
                    r_free[r_slot] <= 1'b0;
                    r_count <= r_count + 1'b1;
                    r_rsp.entry_count <= r_count + 1'b1;
                end
                S_UNLINK_WR: begin
                    if (pv != NilLink) m_next[pv[IdxW-1:0]] <= nx;
                    else r_head <= nx;
                    if (nx != NilLink) m_prev[nx[IdxW-1:0]] <= pv;
                    else r_tail <= pv;
                    r_free[r_at[IdxW-1:0]] <= 1'b1;
                    r_count <= r_count - 1'b1;
                    r_rsp.entry_count <= r_count - 1'b1;
                end
                S_DONE: r_rsp_vld <= 1'b1;
                default: ;
            endcase
        end
    end

    // count tracks the free map
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CntW'(Capacity - $countones(r_free)))
        else $error("count and free map disagree");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == NilLink && r_tail == NilLink))
        else $error("empty list with live head or tail");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !r_rsp_vld)
        else $error("request taken while response pending");
endmodule
